/* design/pmwl_pkg.sv */
// Package with the shared codes, types and command structures of the waiter list.
package pmwl_pkg;

    localparam int IdW   = 32;
    localparam int PrioW = 6;

    typedef logic [2:0] t_status;
    typedef logic [1:0] t_action;
    typedef logic [1:0] t_owner;

    localparam logic    CMD_ADD    = 1'b0;
    localparam logic    CMD_REMOVE = 1'b1;

    localparam t_owner  OWN_NONE  = 2'd0;
    localparam t_owner  OWN_THIS  = 2'd1;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_OWNED_THIS  = 3'd1;
    localparam t_status ST_OWNED_OTHER = 3'd2;
    localparam t_status ST_LISTED      = 3'd3;
    localparam t_status ST_NOT_OWNED   = 3'd4;
    localparam t_status ST_NOT_LISTED  = 3'd5;
    localparam t_status ST_FULL        = 3'd6;

    localparam t_action ACT_NONE  = 2'd0;
    localparam t_action ACT_SET   = 2'd1;
    localparam t_action ACT_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE
    } t_dp_op;

    typedef struct packed {
        logic   load;
        logic   cmp;
        logic   scan;
        t_dp_op op;
    } t_dp_ctrl;

    typedef struct packed {
        logic   command;
        t_owner owner;
        logic   found;
        logic   full;
    } t_dp_stat;

endpackage

/* design/priority_mutex_waiter_list_top.sv */
// Top level of the priority-ordered mutex waiter list.
//
// An add or remove item is taken at a rising edge where start is high and
// busy is low. The block then compares the waiter against every entry cell
// at once, forms the match prefix, applies the insert or delete shift and
// shows the result, in the compare, scan, update and response states. The
// result appears on the o_ ports for exactly one cycle, marked by o_done,
// in the response state; it is registered at the edge leaving update.
// Busy stays high from the accepting edge until the cycle after o_done, so
// no new item is taken before the last one is through; the compare, prefix
// scan, update and result states and one idle state lie before the next accept.
// The result holds the status, the owner mark action, the head entry and
// the count of waiters after the command has been applied.
// A synchronous low reset empties the list and returns the sequencer to
// idle; entry contents are not cleared and are never read before written.
// The receiver cannot stall, so every result is taken in its strobe cycle.
module priority_mutex_waiter_list_top #(
    parameter int MAX_WAITERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [pmwl_pkg::IdW-1:0]    i_waiter_id,
    input  logic [pmwl_pkg::PrioW-1:0]  i_waiter_priority,
    input  logic [1:0]                  i_waiter_owner,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [1:0]                  o_owner_action,
    output logic                        o_head_valid,
    output logic [pmwl_pkg::IdW-1:0]    o_head_id,
    output logic [pmwl_pkg::PrioW-1:0]  o_head_priority,
    output logic [4:0]                  o_waiter_count
);

    pmwl_pkg::t_dp_ctrl ctrl;
    pmwl_pkg::t_dp_stat stat;

    pmwl_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_stat         (stat),
        .o_ctrl         (ctrl),
        .o_busy         (busy),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_owner_action (o_owner_action)
    );

    pmwl_datapath #(
        .MAX_WAITERS (MAX_WAITERS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_command         (i_command),
        .i_waiter_id       (i_waiter_id),
        .i_waiter_priority (i_waiter_priority),
        .i_waiter_owner    (i_waiter_owner),
        .o_stat            (stat),
        .o_head_valid      (o_head_valid),
        .o_head_id         (o_head_id),
        .o_head_priority   (o_head_priority),
        .o_waiter_count    (o_waiter_count)
    );

endmodule

/* design/pmwl_datapath.sv */
// Datapath of the waiter list: a row of entry cells with per-cell compare and shift.
module pmwl_datapath #(
    parameter int MAX_WAITERS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pmwl_pkg::t_dp_ctrl              i_ctrl,
    input  logic                            i_command,
    input  logic [pmwl_pkg::IdW-1:0]        i_waiter_id,
    input  logic [pmwl_pkg::PrioW-1:0]      i_waiter_priority,
    input  pmwl_pkg::t_owner                i_waiter_owner,
    output pmwl_pkg::t_dp_stat              o_stat,
    output logic                            o_head_valid,
    output logic [pmwl_pkg::IdW-1:0]        o_head_id,
    output logic [pmwl_pkg::PrioW-1:0]      o_head_priority,
    output logic [4:0]                      o_waiter_count
);

    localparam int N  = MAX_WAITERS;
    localparam int CW = $clog2(MAX_WAITERS + 1);

    logic                         r_cmd;
    logic [pmwl_pkg::IdW-1:0]     r_id;
    logic [pmwl_pkg::PrioW-1:0]   r_prio;
    pmwl_pkg::t_owner             r_owner;
    logic [pmwl_pkg::IdW-1:0]     r_ids [N];
    logic [pmwl_pkg::PrioW-1:0]   r_pris [N];
    logic [CW-1:0]                r_count;
    logic [N-1:0]                 r_match;
    logic [N-1:0]                 r_gep;
    logic [N-1:0]                 r_pre;
    logic                         r_found;
    logic [N-1:0]                 n_pre;
    logic [N-1:0]                 valid;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid[i] = CW'(i) < r_count;
        end
    end

    always_comb begin
        n_pre = r_match;
        for (int d = 1; d < N; d = d * 2) begin
            n_pre = n_pre | (n_pre << d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_command;
            r_id    <= i_waiter_id;
            r_prio  <= i_waiter_priority;
            r_owner <= i_waiter_owner;
        end
        if (i_ctrl.cmp) begin
            for (int i = 0; i < N; i++) begin
                r_match[i] <= valid[i] && (r_ids[i] == r_id);
                r_gep[i]   <= !valid[i] || (r_prio > r_pris[i]);
            end
        end
        if (i_ctrl.scan) begin
            r_pre   <= n_pre;
            r_found <= n_pre[N-1];
        end
        case (i_ctrl.op)
            pmwl_pkg::OP_INSERT: begin
                if (r_gep[0]) begin
                    r_ids[0]  <= r_id;
                    r_pris[0] <= r_prio;
                end
                for (int i = 1; i < N; i++) begin
                    if (r_gep[i-1]) begin
                        r_ids[i]  <= r_ids[i-1];
                        r_pris[i] <= r_pris[i-1];
                    end else if (r_gep[i]) begin
                        r_ids[i]  <= r_id;
                        r_pris[i] <= r_prio;
                    end
                end
            end
            pmwl_pkg::OP_DELETE: begin
                for (int i = 0; i < N - 1; i++) begin
                    if (r_pre[i]) begin
                        r_ids[i]  <= r_ids[i+1];
                        r_pris[i] <= r_pris[i+1];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_ctrl.op)
                pmwl_pkg::OP_INSERT: r_count <= r_count + CW'(1);
                pmwl_pkg::OP_DELETE: r_count <= r_count - CW'(1);
                default:             r_count <= r_count;
            endcase
        end
    end

    assign o_stat.command  = r_cmd;
    assign o_stat.owner    = r_owner;
    assign o_stat.found    = r_found;
    assign o_stat.full     = (r_count == CW'(N));

    assign o_head_valid    = (r_count != '0);
    assign o_head_id       = o_head_valid ? r_ids[0] : '0;
    assign o_head_priority = o_head_valid ? r_pris[0] : '0;

    generate
        if (CW >= 5) begin : g_cnt_wide
            assign o_waiter_count = r_count[4:0];
        end else begin : g_cnt_narrow
            assign o_waiter_count = 5'(r_count);
        end
    endgenerate

endmodule

/* design/pmwl_controller.sv */
// Controller state machine that sequences compare, scan and update for each item.
module pmwl_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pmwl_pkg::t_dp_stat   i_stat,
    output pmwl_pkg::t_dp_ctrl   o_ctrl,
    output logic                 o_busy,
    output logic                 o_done,
    output pmwl_pkg::t_status    o_status,
    output pmwl_pkg::t_action    o_owner_action
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_UPD,
        S_RESP
    } t_state;

    t_state              r_state;
    logic                r_busy;
    logic                r_done;
    pmwl_pkg::t_status   r_status;
    pmwl_pkg::t_action   r_action;
    pmwl_pkg::t_status   n_status;
    pmwl_pkg::t_action   n_action;
    pmwl_pkg::t_dp_op    n_op;

    always_comb begin
        n_status = pmwl_pkg::ST_OK;
        n_action = pmwl_pkg::ACT_NONE;
        n_op     = pmwl_pkg::OP_NONE;
        if (i_stat.command == pmwl_pkg::CMD_ADD) begin
            if (i_stat.owner == pmwl_pkg::OWN_THIS) begin
                n_status = pmwl_pkg::ST_OWNED_THIS;
            end else if (i_stat.owner != pmwl_pkg::OWN_NONE) begin
                n_status = pmwl_pkg::ST_OWNED_OTHER;
            end else if (i_stat.found) begin
                n_status = pmwl_pkg::ST_LISTED;
            end else if (i_stat.full) begin
                n_status = pmwl_pkg::ST_FULL;
            end else begin
                n_action = pmwl_pkg::ACT_SET;
                n_op     = pmwl_pkg::OP_INSERT;
            end
        end else begin
            if (i_stat.owner != pmwl_pkg::OWN_THIS) begin
                n_status = pmwl_pkg::ST_NOT_OWNED;
            end else if (!i_stat.found) begin
                n_status = pmwl_pkg::ST_NOT_LISTED;
            end else begin
                n_action = pmwl_pkg::ACT_CLEAR;
                n_op     = pmwl_pkg::OP_DELETE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CMP;
                        r_busy  <= 1'b1;
                    end
                end
                S_CMP: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state  <= S_RESP;
                    r_done   <= 1'b1;
                    r_status <= n_status;
                    r_action <= n_action;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_ctrl.load = (r_state == S_IDLE) && i_start;
    assign o_ctrl.cmp  = (r_state == S_CMP);
    assign o_ctrl.scan = (r_state == S_SCAN);
    assign o_ctrl.op   = (r_state == S_UPD) ? n_op : pmwl_pkg::OP_NONE;

    assign o_busy         = r_busy;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_owner_action = r_action;

endmodule

/* verif/tb_priority_mutex_waiter_list_top.sv */
// Self-checking testbench for the priority-ordered mutex waiter list.
`timescale 1ns / 100ps

module tb_priority_mutex_waiter_list_top;

    localparam int               WL_DEPTH   = 16;
    localparam int               ITEM_COUNT = 1250;
    localparam pmwl_pkg::t_owner OWN_OTHER  = 2'd2;
    localparam pmwl_pkg::t_owner OWN_ALT    = 2'd3;

    typedef struct packed {
        pmwl_pkg::t_status              status;
        pmwl_pkg::t_action              action;
        logic                           head_valid;
        logic [pmwl_pkg::IdW-1:0]       head_id;
        logic [pmwl_pkg::PrioW-1:0]     head_prio;
        logic [4:0]                     count;
    } t_wl_result;

    class waiter_list_board;
        logic [pmwl_pkg::IdW-1:0]   ids[WL_DEPTH];
        logic [pmwl_pkg::PrioW-1:0] prios[WL_DEPTH];
        int                         count;
        t_wl_result                 pending_q[$];
        int                         errors;
        int                         checked;
        int                         n_insert;
        int                         n_delete;
        int                         n_full;
        int                         deepest;

        function new();
            count    = 0;
            errors   = 0;
            checked  = 0;
            n_insert = 0;
            n_delete = 0;
            n_full   = 0;
            deepest  = 0;
        endfunction

        function int find_slot(logic [pmwl_pkg::IdW-1:0] id);
            for (int i = 0; i < count; i++) begin
                if (ids[i] == id) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_item(logic cmd, logic [pmwl_pkg::IdW-1:0] id,
                                logic [pmwl_pkg::PrioW-1:0] prio, pmwl_pkg::t_owner own);
            t_wl_result res;
            int         at;
            int         pos;
            res.status = pmwl_pkg::ST_OK;
            res.action = pmwl_pkg::ACT_NONE;
            if (cmd == pmwl_pkg::CMD_ADD) begin
                if (own == pmwl_pkg::OWN_THIS) begin
                    res.status = pmwl_pkg::ST_OWNED_THIS;
                end else if (own != pmwl_pkg::OWN_NONE) begin
                    res.status = pmwl_pkg::ST_OWNED_OTHER;
                end else if (find_slot(id) >= 0) begin
                    res.status = pmwl_pkg::ST_LISTED;
                end else if (count >= WL_DEPTH) begin
                    res.status = pmwl_pkg::ST_FULL;
                    n_full++;
                end else begin
                    at = count;
                    for (int i = 0; i < count; i++) begin
                        if (prio > prios[i]) begin
                            at = i;
                            break;
                        end
                    end
                    for (int i = count; i > at; i--) begin
                        ids[i]   = ids[i-1];
                        prios[i] = prios[i-1];
                    end
                    ids[at]   = id;
                    prios[at] = prio;
                    count++;
                    res.action = pmwl_pkg::ACT_SET;
                    n_insert++;
                    if (count > deepest) begin
                        deepest = count;
                    end
                end
            end else begin
                if (own != pmwl_pkg::OWN_THIS) begin
                    res.status = pmwl_pkg::ST_NOT_OWNED;
                end else begin
                    pos = find_slot(id);
                    if (pos < 0) begin
                        res.status = pmwl_pkg::ST_NOT_LISTED;
                    end else begin
                        for (int i = pos; i + 1 < count; i++) begin
                            ids[i]   = ids[i+1];
                            prios[i] = prios[i+1];
                        end
                        count--;
                        res.action = pmwl_pkg::ACT_CLEAR;
                        n_delete++;
                    end
                end
            end
            res.head_valid = (count > 0);
            res.head_id    = (count > 0) ? ids[0] : '0;
            res.head_prio  = (count > 0) ? prios[0] : '0;
            res.count      = 5'(count);
            pending_q.push_back(res);
        endfunction

        function void check_result(t_wl_result got);
            t_wl_result want;
            if (pending_q.size() == 0) begin
                $error("result with no item pending");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.action !== want.action) begin
                $error("owner_action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.head_valid !== want.head_valid) begin
                $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
                errors++;
            end
            if (got.head_id !== want.head_id) begin
                $error("head_id: expected %h, got %h", want.head_id, got.head_id);
                errors++;
            end
            if (got.head_prio !== want.head_prio) begin
                $error("head_priority: expected %0d, got %0d", want.head_prio, got.head_prio);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("waiter_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk             = 1'b0;
    logic                       i_rst_n           = 1'b0;
    logic                       start             = 1'b0;
    logic                       busy;
    logic                       i_command         = 1'b0;
    logic [pmwl_pkg::IdW-1:0]   i_waiter_id       = '0;
    logic [pmwl_pkg::PrioW-1:0] i_waiter_priority = '0;
    logic [1:0]                 i_waiter_owner    = '0;
    logic                       o_done;
    logic [2:0]                 o_status;
    logic [1:0]                 o_owner_action;
    logic                       o_head_valid;
    logic [pmwl_pkg::IdW-1:0]   o_head_id;
    logic [pmwl_pkg::PrioW-1:0] o_head_priority;
    logic [4:0]                 o_waiter_count;

    waiter_list_board           board = new();
    logic [pmwl_pkg::IdW-1:0]   id_pool[32];
    int                         items_sent = 0;

    priority_mutex_waiter_list_top #(
        .MAX_WAITERS(WL_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_waiter_id(i_waiter_id),
        .i_waiter_priority(i_waiter_priority),
        .i_waiter_owner(i_waiter_owner),
        .o_done(o_done),
        .o_status(o_status),
        .o_owner_action(o_owner_action),
        .o_head_valid(o_head_valid),
        .o_head_id(o_head_id),
        .o_head_priority(o_head_priority),
        .o_waiter_count(o_waiter_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_result({o_status, o_owner_action, o_head_valid, o_head_id,
                                o_head_priority, o_waiter_count});
        end
    end

    task automatic issue_item(input logic cmd, input logic [pmwl_pkg::IdW-1:0] id,
                              input logic [pmwl_pkg::PrioW-1:0] prio,
                              input pmwl_pkg::t_owner own);
        start             <= 1'b1;
        i_command         <= cmd;
        i_waiter_id       <= id;
        i_waiter_priority <= prio;
        i_waiter_owner    <= own;
        do @(posedge i_clk); while (busy);
        board.note_item(cmd, id, prio, own);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [pmwl_pkg::PrioW-1:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return pmwl_pkg::PrioW'($urandom_range(30, 33));
            default: return pmwl_pkg::PrioW'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [pmwl_pkg::IdW-1:0] pick_id();
        if ($urandom_range(0, 1) == 0) begin
            return id_pool[$urandom_range(0, 31)];
        end
        return $urandom;
    endfunction

    function automatic logic [pmwl_pkg::IdW-1:0] listed_id();
        if (board.count == 0) begin
            return pick_id();
        end
        return board.ids[$urandom_range(0, board.count - 1)];
    endfunction

    task automatic random_item(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 60 : 25)) begin
            issue_item(pmwl_pkg::CMD_ADD, pick_id(), pick_prio(), pmwl_pkg::OWN_NONE);
        end else if (roll < 80) begin
            issue_item(pmwl_pkg::CMD_REMOVE, listed_id(), pmwl_pkg::PrioW'($urandom),
                       pmwl_pkg::OWN_THIS);
        end else begin
            case ($urandom_range(0, 3))
                0: issue_item(pmwl_pkg::CMD_ADD, listed_id(), pmwl_pkg::PrioW'($urandom),
                              pmwl_pkg::OWN_NONE);
                1: issue_item(pmwl_pkg::CMD_REMOVE, listed_id(), pmwl_pkg::PrioW'($urandom),
                              ($urandom_range(0, 1) == 0) ? pmwl_pkg::OWN_NONE
                              : pmwl_pkg::t_owner'($urandom_range(2, 3)));
                2: issue_item(pmwl_pkg::CMD_ADD, pick_id(), pmwl_pkg::PrioW'($urandom),
                              pmwl_pkg::t_owner'($urandom_range(1, 3)));
                default: issue_item(pmwl_pkg::CMD_REMOVE, $urandom,
                                    pmwl_pkg::PrioW'($urandom), pmwl_pkg::OWN_THIS);
            endcase
        end
    endtask

    initial begin
        bit filling;
        bit gappy;
        int phase_left;
        for (int i = 0; i < 32; i++) begin
            id_pool[i] = $urandom;
        end
        id_pool[0] = '0;
        id_pool[1] = '1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue_item(pmwl_pkg::CMD_REMOVE, 32'h1234_5678, 6'd5, pmwl_pkg::OWN_THIS);
        issue_item(pmwl_pkg::CMD_REMOVE, 32'h1234_5678, 6'd5, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_REMOVE, 32'h1234_5678, 6'd5, OWN_OTHER);
        issue_item(pmwl_pkg::CMD_REMOVE, 32'h1234_5678, 6'd5, OWN_ALT);
        issue_item(pmwl_pkg::CMD_ADD, 32'h1234_5678, 6'd5, pmwl_pkg::OWN_THIS);
        issue_item(pmwl_pkg::CMD_ADD, 32'h1234_5678, 6'd5, OWN_OTHER);
        issue_item(pmwl_pkg::CMD_ADD, 32'h1234_5678, 6'd5, OWN_ALT);
        issue_item(pmwl_pkg::CMD_ADD, 32'h0000_0000, 6'd0, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd63, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd10, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_ADD, 32'hA5A5_5A5A, 6'd63, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_ADD, 32'h5A5A_A5A5, 6'd0, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 6'd0, pmwl_pkg::OWN_THIS);
        issue_item(pmwl_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0, pmwl_pkg::OWN_THIS);
        while (board.count < WL_DEPTH) begin
            issue_item(pmwl_pkg::CMD_ADD, $urandom, pmwl_pkg::PrioW'($urandom_range(0, 63)),
                       pmwl_pkg::OWN_NONE);
        end
        issue_item(pmwl_pkg::CMD_ADD, 32'hC0DE_0001, 6'd63, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_ADD, 32'hA5A5_5A5A, 6'd1, pmwl_pkg::OWN_NONE);
        issue_item(pmwl_pkg::CMD_ADD, 32'hC0DE_0002, 6'd1, pmwl_pkg::OWN_THIS);

        filling    = 1'b0;
        gappy      = 1'b1;
        phase_left = 0;
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (phase_left == 0) begin
                filling    = ~filling;
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            if (n % 50 == 0) begin
                gappy = ($urandom_range(0, 2) != 0);
            end
            random_item(filling);
            if (n < ITEM_COUNT - 150 && gappy && $urandom_range(0, 9) < 3) begin
                idle_cycles($urandom_range(1, 11));
            end
        end
        start <= 1'b0;

        while (board.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results: %0d inserts, %0d deletes,",
                 items_sent, board.checked, board.n_insert, board.n_delete);
        $display("%0d adds turned away by a full list, longest list %0d entries.",
                 board.n_full, board.deepest);
        if (board.errors == 0) begin
            $display("tb_priority_mutex_waiter_list_top: done, clean");
        end else begin
            $display("tb_priority_mutex_waiter_list_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still pending.", board.pending_q.size());
        $display("tb_priority_mutex_waiter_list_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/pmwl_pkg.sv
design/pmwl_datapath.sv
design/pmwl_controller.sv
design/priority_mutex_waiter_list_top.sv
verif/tb_priority_mutex_waiter_list_top.sv
